/* rtl/core/lfds_pkg.sv */
// Shared types and constants of the line follower drive step.
`default_nettype none

package lfds_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_LINE_THRESHOLD  = 3'd0,
    CFG_CRUISE_SPEED    = 3'd1,
    CFG_STEER_SPEED     = 3'd2,
    CFG_BACKUP_SPEED    = 3'd3,
    CFG_CORRECTION_GAIN = 3'd4,
    CFG_LOSS_TIMEOUT_MS = 3'd5,
    CFG_FAULT_LIMIT     = 3'd6,
    CFG_BACKUP_HOLD_MS  = 3'd7
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef struct packed {
    logic [11:0] line_threshold;
    logic [7:0]  cruise_speed;
    logic [7:0]  steer_speed;
    logic [7:0]  backup_speed;
    logic [7:0]  correction_gain;
    logic [15:0] loss_timeout_ms;
    logic [7:0]  fault_limit;
    logic [7:0]  backup_hold_ms;
  } cfg_t;

  localparam logic [11:0] RST_LINE_THRESHOLD  = 12'd2000;
  localparam logic [7:0]  RST_CRUISE_SPEED    = 8'd150;
  localparam logic [7:0]  RST_STEER_SPEED     = 8'd200;
  localparam logic [7:0]  RST_BACKUP_SPEED    = 8'd120;
  localparam logic [7:0]  RST_CORRECTION_GAIN = 8'd40;
  localparam logic [15:0] RST_LOSS_TIMEOUT_MS = 16'd1500;
  localparam logic [7:0]  RST_FAULT_LIMIT     = 8'd3;
  localparam logic [7:0]  RST_BACKUP_HOLD_MS  = 8'd30;

  localparam logic [7:0] SPIN_HOLD_MS = 8'd80;
  localparam logic [7:0] BIG_ERROR    = 8'd2;
  localparam int         DRIVE_MAX    = 255;
  localparam logic [7:0] FAULT_MAX    = 8'd255;

  // Result item: left 9b, right 9b, hold 8b, stop 1b, zero pad to 32b.
  localparam int unsigned OUT_W = 32;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_MUL,
    ST_DRIVE,
    ST_STOP,
    ST_REV,
    ST_SPIN
  } back_state_e;

endpackage

`default_nettype wire

/* rtl/core/lfds_queue.sv */
// Two-entry queue that carries classified items from the front to the back part.
`default_nettype none

module lfds_queue #(
  parameter int unsigned WIDTH = 39,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      head_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lfds_front.sv */
// Front part: accepts input items and reduces the samples to a hit mask.
`default_nettype none

module lfds_front #(
  parameter int unsigned SENSORS     = 5,
  parameter int unsigned SAMPLE_BITS = 12,
  localparam int unsigned IN_BITS    = 1 + SENSORS * SAMPLE_BITS + SENSORS + 1 + 32,
  localparam int unsigned IN_W       = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned REC_W      = SENSORS + 34
) (
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [IN_W-1:0]    s_axis_tdata_i,
  input  wire logic [11:0]        threshold_i,
  input  wire logic               queue_full_i,
  output logic                    push_o,
  output logic [REC_W-1:0]        rec_o
);

  localparam int unsigned MASK_LSB = 1 + SENSORS * SAMPLE_BITS;
  localparam int unsigned CMP_W    = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;

  logic               enable;
  logic               healthy;
  logic [SENSORS-1:0] valid_mask;
  logic [31:0]        now_ms;
  logic [SENSORS-1:0] hit;

  assign enable     = s_axis_tdata_i[0];
  assign valid_mask = s_axis_tdata_i[MASK_LSB +: SENSORS];
  assign healthy    = s_axis_tdata_i[MASK_LSB + SENSORS];
  assign now_ms     = s_axis_tdata_i[MASK_LSB + SENSORS + 1 +: 32];

  // A sensor is on the line when it is valid and darker than the threshold.
  always_comb begin
    for (int i = 0; i < SENSORS; i++) begin
      hit[i] = valid_mask[i] &&
               (CMP_W'(s_axis_tdata_i[1 + i * SAMPLE_BITS +: SAMPLE_BITS]) <
                CMP_W'(threshold_i));
    end
  end

  assign s_axis_tready_o = !queue_full_i;
  assign push_o          = s_axis_tvalid_i && !queue_full_i;
  assign rec_o           = {now_ms, healthy, enable, hit};

endmodule

`default_nettype wire

/* rtl/core/lfds_div.sv */
// Small divider by repeated subtraction for the line error.
`default_nettype none

module lfds_div #(
  parameter int unsigned NUM_W = 3,
  parameter int unsigned DEN_W = 3,
  parameter int unsigned QUO_W = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [QUO_W-1:0]      quo_o
);

  localparam int unsigned CW = (NUM_W > DEN_W) ? NUM_W : DEN_W;

  logic             busy_q;
  logic [NUM_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [QUO_W-1:0] quo_q;
  logic             ge;

  assign ge     = CW'(rem_q) >= CW'(den_q);
  assign done_o = busy_q && !ge;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && !ge) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q && ge) begin
      rem_q <= NUM_W'(CW'(rem_q) - CW'(den_q));
      quo_q <= quo_q + 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lfds_back.sv */
// Back part: sequences one item at a time and drives the result register.
`default_nettype none

module lfds_back #(
  parameter int unsigned SENSORS = 5,
  localparam int unsigned REC_W  = SENSORS + 34
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lfds_pkg::cfg_t       cfg_i,
  input  wire logic [REC_W-1:0]     head_i,
  input  wire logic                 empty_i,
  output logic                      pop_o,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [lfds_pkg::OUT_W-1:0] m_axis_tdata_o,
  output logic                      m_axis_tlast_o
);

  import lfds_pkg::*;

  localparam int HALF   = SENSORS / 2;
  localparam int ERR_W  = $clog2(HALF + 1) + 1;
  localparam int QUO_W  = ERR_W - 1;
  localparam int SUM_W  = $clog2(HALF * (HALF + 1) / 2 + 1) + 1;
  localparam int CNT_W  = $clog2(SENSORS + 1);
  localparam int CORR_W = ERR_W + 9;
  localparam int DRV_W  = CORR_W + 1;

  back_state_e state_q, state_d;

  // Item under work.
  logic                    en_q, healthy_q;
  logic [31:0]             now_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0]        hits_q;

  // Controller state.
  logic [31:0]             seen_q;
  logic signed [ERR_W-1:0] prev_q;
  logic [7:0]              fault_q;

  logic signed [ERR_W-1:0]  err_q;
  logic                     big_q;
  logic signed [CORR_W-1:0] corr_q;

  // Result register.
  logic       out_valid_q;
  logic [8:0] out_left_q, out_right_q;
  logic [7:0] out_hold_q;
  logic       out_stop_q, out_last_q;

  logic [SENSORS-1:0]      head_hit;
  logic signed [SUM_W-1:0] head_sum;
  logic [CNT_W-1:0]        head_hits;
  logic [7:0]              fc_inc;
  logic                    fault_stop;
  logic [31:0]             elapsed;
  logic                    timed_out;
  logic                    can_emit;
  logic                    load_out;
  logic [8:0]              nx_left, nx_right;
  logic [7:0]              nx_hold;
  logic                    nx_stop, nx_last;
  logic                    div_start, div_done;
  logic [QUO_W-1:0]        quo;
  logic                    neg;
  logic [SUM_W-1:0]        mag;
  logic signed [ERR_W-1:0] err_new;
  logic signed [DRV_W-1:0] base_ext, corr_ext, l_raw, r_raw;
  logic [8:0]              turn9, rev9;
  logic                    dpos;

  function automatic logic [8:0] clamp9(input logic signed [DRV_W-1:0] v);
    logic [8:0] r;
    if (v > DRV_W'(DRIVE_MAX)) begin
      r = 9'(DRIVE_MAX);
    end else if (v < DRV_W'(-DRIVE_MAX)) begin
      r = 9'(-DRIVE_MAX);
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

  // Weighted sum and hit count of the queue head, weight i - SENSORS/2.
  assign head_hit = head_i[SENSORS-1:0];
  always_comb begin
    head_sum  = '0;
    head_hits = '0;
    for (int i = 0; i < SENSORS; i++) begin
      if (head_hit[i]) begin
        head_sum  = head_sum + SUM_W'(i - HALF);
        head_hits = head_hits + 1'b1;
      end
    end
  end

  assign fc_inc     = (fault_q == FAULT_MAX) ? FAULT_MAX : fault_q + 1'b1;
  assign fault_stop = !healthy_q && (fc_inc >= cfg_i.fault_limit);
  assign elapsed    = now_q - seen_q;
  assign timed_out  = elapsed > {16'b0, cfg_i.loss_timeout_ms};
  assign can_emit   = !out_valid_q || m_axis_tready_i;

  assign neg = sum_q[SUM_W-1];
  assign mag = neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  lfds_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W),
    .QUO_W(QUO_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (mag),
    .den_i  (hits_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign err_new = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  assign base_ext = DRV_W'({1'b0, big_q ? cfg_i.steer_speed : cfg_i.cruise_speed});
  assign corr_ext = DRV_W'(corr_q);
  assign l_raw    = base_ext - corr_ext;
  assign r_raw    = base_ext + corr_ext;

  assign turn9 = {1'b0, cfg_i.steer_speed};
  assign rev9  = -{1'b0, cfg_i.backup_speed};
  assign dpos  = !prev_q[ERR_W-1];

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    nx_left   = '0;
    nx_right  = '0;
    nx_hold   = '0;
    nx_stop   = 1'b0;
    nx_last   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!en_q || fault_stop) begin
          state_d = ST_STOP;
        end else if (hits_q == '0) begin
          state_d = timed_out ? ST_STOP : ST_REV;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DRIVE;
      end
      ST_DRIVE: begin
        nx_left  = clamp9(l_raw);
        nx_right = clamp9(r_raw);
        if (can_emit) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_STOP: begin
        nx_stop = 1'b1;
        if (can_emit) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_REV: begin
        nx_left  = rev9;
        nx_right = rev9;
        nx_hold  = cfg_i.backup_hold_ms;
        nx_last  = 1'b0;
        if (can_emit) begin
          load_out = 1'b1;
          state_d  = ST_SPIN;
        end
      end
      ST_SPIN: begin
        nx_left  = dpos ? -turn9 : turn9;
        nx_right = dpos ? turn9 : -turn9;
        nx_hold  = SPIN_HOLD_MS;
        if (can_emit) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      seen_q      <= '0;
      prev_q      <= '0;
      fault_q     <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_DECIDE) begin
        if (!en_q) begin
          seen_q  <= now_q;
          prev_q  <= '0;
          fault_q <= '0;
        end else if (!healthy_q) begin
          fault_q <= fc_inc;
        end else begin
          fault_q <= '0;
        end
      end
      if (state_q == ST_DIV && div_done) begin
        seen_q <= now_q;
        prev_q <= err_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      en_q      <= head_i[SENSORS];
      healthy_q <= head_i[SENSORS+1];
      now_q     <= head_i[SENSORS+2 +: 32];
      sum_q     <= head_sum;
      hits_q    <= head_hits;
    end
    if (state_q == ST_DIV && div_done) begin
      err_q <= err_new;
      big_q <= ({{(8 - QUO_W){1'b0}}, quo} >= BIG_ERROR);
    end
    if (state_q == ST_MUL) begin
      corr_q <= err_q * $signed({1'b0, cfg_i.correction_gain});
    end
    if (load_out) begin
      out_left_q  <= nx_left;
      out_right_q <= nx_right;
      out_hold_q  <= nx_hold;
      out_stop_q  <= nx_stop;
      out_last_q  <= nx_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_stop_q, out_hold_q, out_right_q, out_left_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef ASSERT_OFF
  // The divider never starts without at least one sensor on the line.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> hits_q != '0)
    else $error("divider started with zero hits");

  // A stop result always carries zero drives and no hold.
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stop_q) |->
      (out_left_q == '0 && out_right_q == '0 && out_hold_q == '0 && out_last_q))
    else $error("stop result with nonzero payload");

  // The result register is only reloaded once its item is gone.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || m_axis_tready_i))
    else $error("result register overwritten while stalled");

  // The first result of a search pair is followed by the spin result.
  a_rev_then_spin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !nx_last) |=> state_q == ST_SPIN)
    else $error("reverse result not followed by spin");
`endif

endmodule

`default_nettype wire

/* rtl/core/line_follower_drive_step.sv */
// Top level of the line follower drive step: config registers, front, queue, back.
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+-----------------------------------
//  s_axis   | in        | s_axis_tvalid/tready     | tdata: enable, sensors, mask, ...
//  m_axis   | out       | m_axis_tvalid/tready     | tdata: drives, hold, stop; tlast
//  cfg      | in        | cfg_valid_i/cfg_ready_o  | cfg_index_i, cfg_data_i
//
// In the back part an item passes IDLE and DECIDE, then STOP when it ends in a stop,
// REV and SPIN when it starts a line search (two results), or DIV, MUL and DRIVE when
// the line is found, where the repeated-subtraction divider sets the time in DIV.
// Reset clears the controller state and loads the register defaults; there is no
// clearing pass. A two-item queue sits between the front and back parts, so input
// items are still taken while a result waits in the output register.
`default_nettype none

module line_follower_drive_step #(
  parameter int unsigned SENSORS     = 5,
  parameter int unsigned SAMPLE_BITS = 12,
  localparam int unsigned IN_BITS    = 1 + SENSORS * SAMPLE_BITS + SENSORS + 1 + 32,
  localparam int unsigned IN_W       = ((IN_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tdata, from bit 0: enable, sensor_0 .. sensor_N-1, valid_mask, healthy, now_ms, pad
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [IN_W-1:0]               s_axis_tdata_i,
  // tdata, from bit 0: left_drive, right_drive, hold_ms, stop, zero pad
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [lfds_pkg::OUT_W-1:0]         m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lfds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lfds_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import lfds_pkg::*;

  localparam int unsigned REC_W = SENSORS + 34;

  cfg_t cfg_q;

  logic             push;
  logic [REC_W-1:0] rec;
  logic             queue_full;
  logic             pop;
  logic [REC_W-1:0] head;
  logic             queue_empty;

  // Registers are written whenever presented; the block is idle by contract.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_threshold  <= RST_LINE_THRESHOLD;
      cfg_q.cruise_speed    <= RST_CRUISE_SPEED;
      cfg_q.steer_speed     <= RST_STEER_SPEED;
      cfg_q.backup_speed    <= RST_BACKUP_SPEED;
      cfg_q.correction_gain <= RST_CORRECTION_GAIN;
      cfg_q.loss_timeout_ms <= RST_LOSS_TIMEOUT_MS;
      cfg_q.fault_limit     <= RST_FAULT_LIMIT;
      cfg_q.backup_hold_ms  <= RST_BACKUP_HOLD_MS;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LINE_THRESHOLD:  cfg_q.line_threshold  <= cfg_data_i[11:0];
        CFG_CRUISE_SPEED:    cfg_q.cruise_speed    <= cfg_data_i[7:0];
        CFG_STEER_SPEED:     cfg_q.steer_speed     <= cfg_data_i[7:0];
        CFG_BACKUP_SPEED:    cfg_q.backup_speed    <= cfg_data_i[7:0];
        CFG_CORRECTION_GAIN: cfg_q.correction_gain <= cfg_data_i[7:0];
        CFG_LOSS_TIMEOUT_MS: cfg_q.loss_timeout_ms <= cfg_data_i[15:0];
        CFG_FAULT_LIMIT:     cfg_q.fault_limit     <= cfg_data_i[7:0];
        CFG_BACKUP_HOLD_MS:  cfg_q.backup_hold_ms  <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // The front part compares every sample against the threshold as the item is taken.
  lfds_front #(
    .SENSORS    (SENSORS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .threshold_i    (cfg_q.line_threshold),
    .queue_full_i   (queue_full),
    .push_o         (push),
    .rec_o          (rec)
  );

  lfds_queue #(
    .WIDTH(REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(rec),
    .full_o     (queue_full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (queue_empty)
  );

  // The back part holds the controller state and owns the result register.
  lfds_back #(
    .SENSORS(SENSORS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_i         (head),
    .empty_i        (queue_empty),
    .pop_o          (pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
